// ===== rtl/lsfc_pkg.sv =====
// Shared types, constants and lookup functions of the LED strip fade controller.
`timescale 1ns / 1ps
`default_nettype none
package lsfc_pkg;

  localparam int LSFC_LED_COUNT = 10;

  localparam int InDataW  = 72;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BRIGHT_LVL = 3'd0,
    CFG_FWD_IDX    = 3'd1,
    CFG_BWD_IDX    = 3'd2,
    CFG_IDLE_MODE  = 3'd3,
    CFG_CELLS      = 3'd4,
    CFG_IDLE_DELAY = 3'd5
  } lsfc_cfg_idx_t;

  // Idle display modes
  localparam logic [1:0] IDLE_NORMAL  = 2'd0;
  localparam logic [1:0] IDLE_BAT_COL = 2'd1;
  localparam logic [1:0] IDLE_BAT_BAR = 2'd2;
  localparam logic [1:0] IDLE_OFF     = 2'd3;

  // Menu numbers with a meaning of their own
  localparam logic [3:0] MENU_NONE     = 4'd0;
  localparam logic [3:0] MENU_DIR_LAST = 4'd3;
  localparam logic [3:0] MENU_DIR_REV  = 4'd3;
  localparam logic [3:0] MENU_IDLE_SEL = 4'd4;
  localparam logic [3:0] MENU_CELLS    = 4'd5;

  localparam logic [31:0] PREVIEW_COLOR = 32'h0064_6464;
  localparam logic [31:0] MODE_COLOR    = 32'h0000_6400;
  localparam logic [31:0] CELLS_COLOR   = 32'h0000_0064;

  localparam logic [7:0] FADE_STEP   = 8'd20;
  localparam logic [8:0] DIM_STEP    = 9'd10;
  localparam logic [8:0] RISE_STEP   = 9'd30;
  localparam logic signed [20:0] SPEED_DEADBAND = 21'sd25;
  localparam logic [15:0] BAR_DIVISOR = 16'd510;

  localparam logic [1:0]  RST_BRIGHT_LVL = 2'd0;
  localparam logic [2:0]  RST_FWD_IDX    = 3'd0;
  localparam logic [2:0]  RST_BWD_IDX    = 3'd5;
  localparam logic [1:0]  RST_IDLE_MODE  = IDLE_NORMAL;
  localparam logic [5:0]  RST_CELLS      = 6'd12;
  localparam logic [15:0] RST_IDLE_DELAY = 16'd2000;

  // Input item, last field in the lowest bits
  typedef struct packed {
    logic [7:0]         battery_level;
    logic [3:0]         long_press_count;
    logic [3:0]         press_count;
    logic [31:0]        now_ms;
    logic signed [20:0] motor_speed;
    logic               switch_active;
  } lsfc_item_t;

  typedef struct packed {
    logic [1:0]  brightness_level;
    logic [2:0]  forward_color_index;
    logic [2:0]  backward_color_index;
    logic [1:0]  idle_display_mode;
    logic [5:0]  battery_series_cells;
    logic [15:0] idle_delay_ms;
  } lsfc_cfg_t;

  // Per-tick state apart from the LED mask
  typedef struct packed {
    logic        heading_fwd;
    logic [31:0] last_act_ms;
    logic        idle_faded;
    logic [31:0] front_shown;
    logic [31:0] rear_shown;
    logic [31:0] front_lit;
    logic [31:0] rear_lit;
    logic [7:0]  cur_bright;
    logic [1:0]  seen_bright_lvl;
    logic [2:0]  seen_fwd_idx;
    logic [2:0]  seen_bwd_idx;
  } lsfc_state_t;

  // Palette; index seven saturates to entry six
  function automatic logic [31:0] pal_color(input logic [2:0] idx);
    logic [31:0] c;
    case (idx)
      3'd0:    c = 32'hFFFF_FFFF;
      3'd1:    c = 32'h0000_00FF;
      3'd2:    c = 32'h0000_FFFF;
      3'd3:    c = 32'h0000_FF00;
      3'd4:    c = 32'h00FF_FF00;
      3'd5:    c = 32'h00FF_0000;
      default: c = 32'h00FF_00FF;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] active_lvl(input logic [1:0] lvl);
    logic [7:0] b;
    case (lvl)
      2'd0:    b = 8'hFF;
      2'd1:    b = 8'h88;
      2'd2:    b = 8'h44;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] idle_lvl(input logic [1:0] lvl);
    logic [7:0] b;
    case (lvl)
      2'd0:    b = 8'h0A;
      2'd1:    b = 8'h05;
      2'd2:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/led_strip_fade_controller_core.sv =====
// Top level of the LED strip fade controller: request registers, state and result.
`timescale 1ns / 1ps
`default_nettype none
// One update request per tick drives two LED strips. Each request carries the foot
// switch, signed motor speed, millisecond time, button counts and battery level;
// each yields exactly one result: front colour, rear colour (W R G B bytes), a
// lit-LED mask shared by both strips and a global brightness. Requests are taken
// into an input register; the whole update is one pass of shallow compare/add
// logic from that register into the state registers, which double as the result
// register. Throughput is one request per clock unless the output stalls, and a
// result is registered as its request advances. A new request is taken while a
// result waits, and the input register holds one more request during an output
// stall. Travel direction latches outside a +-25 deadband, colours fade by 20 per
// byte per tick, brightness falls by 10 or rises by 30 per tick toward the active
// or idle level. Configuration is written through cfg_we/cfg_index/cfg_wdata and
// must only change while no request is in flight; unknown indexes are dropped.
module led_strip_fade_controller_core
  import lsfc_pkg::*;
#(
  parameter  int LED_COUNT = LSFC_LED_COUNT,
  localparam int OutDataW  = ((64 + LED_COUNT + 8 + 7) / 8) * 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // switch_active, motor_speed, now_ms, press_count, long_press_count,
  // battery_level, zero padding
  input  wire logic [InDataW-1:0]   in_tdata,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // front_color, rear_color, lit_mask, strip_brightness, zero padding
  output logic      [OutDataW-1:0]  out_tdata,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_wdata
);

  lsfc_cfg_t            cfg_r;
  lsfc_item_t           item_r;
  logic                 item_v_r;
  logic                 out_v_r;
  lsfc_state_t          st_r;
  lsfc_state_t          st_nxt;
  logic [LED_COUNT-1:0] mask_r;
  logic [LED_COUNT-1:0] mask_nxt;
  logic                 advance;
  lsfc_cfg_idx_t        cfg_sel;

  // Advance the held request when the result slot is free or being emptied
  assign advance   = item_v_r && (!out_v_r || out_tready);
  assign in_tready = !item_v_r || advance;

  // Configuration registers
  assign cfg_sel = lsfc_cfg_idx_t'(cfg_index);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness_level     <= RST_BRIGHT_LVL;
      cfg_r.forward_color_index  <= RST_FWD_IDX;
      cfg_r.backward_color_index <= RST_BWD_IDX;
      cfg_r.idle_display_mode    <= RST_IDLE_MODE;
      cfg_r.battery_series_cells <= RST_CELLS;
      cfg_r.idle_delay_ms        <= RST_IDLE_DELAY;
    end else if (cfg_we) begin
      case (cfg_sel)
        CFG_BRIGHT_LVL: cfg_r.brightness_level     <= cfg_wdata[1:0];
        CFG_FWD_IDX:    cfg_r.forward_color_index  <= cfg_wdata[2:0];
        CFG_BWD_IDX:    cfg_r.backward_color_index <= cfg_wdata[2:0];
        CFG_IDLE_MODE:  cfg_r.idle_display_mode    <= cfg_wdata[1:0];
        CFG_CELLS:      cfg_r.battery_series_cells <= cfg_wdata[5:0];
        CFG_IDLE_DELAY: cfg_r.idle_delay_ms        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: payload needs no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= lsfc_item_t'(in_tdata[$bits(lsfc_item_t)-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      item_v_r <= 1'b1;
    end else if (advance) begin
      item_v_r <= 1'b0;
    end
  end

  lsfc_update #(
    .LED_COUNT (LED_COUNT)
  ) u_update (
    .item_i (item_r),
    .cfg_i  (cfg_r),
    .st_i   (st_r),
    .mask_i (mask_r),
    .st_o   (st_nxt),
    .mask_o (mask_nxt)
  );

  // State and result registers; hold everything while the result is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.heading_fwd     <= 1'b1;
      st_r.last_act_ms     <= '0;
      st_r.idle_faded      <= 1'b0;
      st_r.front_shown     <= pal_color(RST_FWD_IDX);
      st_r.rear_shown      <= pal_color(RST_BWD_IDX);
      st_r.front_lit       <= pal_color(RST_FWD_IDX);
      st_r.rear_lit        <= pal_color(RST_BWD_IDX);
      st_r.cur_bright      <= '0;
      st_r.seen_bright_lvl <= RST_BRIGHT_LVL;
      st_r.seen_fwd_idx    <= RST_FWD_IDX;
      st_r.seen_bwd_idx    <= RST_BWD_IDX;
      mask_r               <= '1;
    end else if (advance) begin
      st_r   <= st_nxt;
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;

  always_comb begin
    out_tdata                       = '0;
    out_tdata[31:0]                 = st_r.front_lit;
    out_tdata[63:32]                = st_r.rear_lit;
    out_tdata[64 +: LED_COUNT]      = mask_r;
    out_tdata[64 + LED_COUNT +: 8]  = st_r.cur_bright;
  end

endmodule
`default_nettype wire

// ===== rtl/lsfc_fade.sv =====
// Per-byte W/R/G/B colour fade by a fixed step toward a target colour.
`timescale 1ns / 1ps
`default_nettype none
module lsfc_fade
  import lsfc_pkg::*;
(
  input  wire logic [31:0] cur_i,
  input  wire logic [31:0] want_i,
  output logic      [31:0] res_o
);

  always_comb begin
    logic [7:0] c;
    logic [7:0] d;
    logic [7:0] diff;
    res_o = '0;
    for (int b = 0; b < 4; b++) begin
      c    = cur_i[8*b +: 8];
      d    = want_i[8*b +: 8];
      diff = (d > c) ? (d - c) : (c - d);
      if (diff < FADE_STEP) begin
        res_o[8*b +: 8] = d;
      end else if (d > c) begin
        res_o[8*b +: 8] = c + FADE_STEP;
      end else begin
        res_o[8*b +: 8] = c - FADE_STEP;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lsfc_update.sv =====
// Next-state logic for one update tick: menus, direction, idle, fades, brightness.
`timescale 1ns / 1ps
`default_nettype none
module lsfc_update
  import lsfc_pkg::*;
#(
  parameter int LED_COUNT = LSFC_LED_COUNT
) (
  input  wire lsfc_item_t            item_i,
  input  wire lsfc_cfg_t             cfg_i,
  input  wire lsfc_state_t           st_i,
  input  wire logic [LED_COUNT-1:0]  mask_i,
  output lsfc_state_t                st_o,
  output logic      [LED_COUNT-1:0]  mask_o
);

  function automatic logic [LED_COUNT-1:0] low_bits(input logic [5:0] n);
    logic [LED_COUNT-1:0] m;
    for (int i = 0; i < LED_COUNT; i++) begin
      m[i] = (int'(n) > i);
    end
    return m;
  endfunction

  logic        menu_any;
  logic        menu_preview;
  logic        menu_dir;
  logic        menu_mode;
  logic        menu_cells;
  logic        heading;
  logic [31:0] last_act;
  logic        idle;
  logic        idle_faded;
  logic        idx_change;
  logic [31:0] lead;
  logic [31:0] trail;
  logic [31:0] front_tgt;
  logic [31:0] rear_tgt;
  logic [31:0] front_base;
  logic [31:0] rear_base;
  logic [31:0] bat_color;
  logic        normal_disp;
  logic [31:0] front_faded;
  logic [31:0] rear_faded;
  logic [9:0]  cells_x13;
  logic [3:0]  cells_q;
  logic [5:0]  cells_r;
  logic [2:0]  cells_n;
  logic [15:0] bar_num;
  logic [LED_COUNT-1:0] bar_mask;
  logic [LED_COUNT-1:0] preview_mask;
  logic [7:0]  bright_tgt;
  logic [8:0]  cur_ext;
  logic [8:0]  tgt_ext;

  assign menu_any     = (item_i.press_count != MENU_NONE);
  assign menu_preview = menu_any && (item_i.long_press_count == 4'd0);
  assign menu_dir     = menu_any && !menu_preview && (item_i.press_count <= MENU_DIR_LAST);
  assign menu_mode    = !menu_preview && (item_i.press_count == MENU_IDLE_SEL);
  assign menu_cells   = !menu_preview && (item_i.press_count == MENU_CELLS);

  // Direction: menu sets it first, speed outside the deadband overrides
  always_comb begin
    heading = menu_dir ? (item_i.press_count != MENU_DIR_REV) : st_i.heading_fwd;
    if (item_i.motor_speed > SPEED_DEADBAND) begin
      heading = 1'b1;
    end else if (item_i.motor_speed < -SPEED_DEADBAND) begin
      heading = 1'b0;
    end
  end

  assign last_act   = item_i.switch_active ? item_i.now_ms : st_i.last_act_ms;
  assign idle       = ((item_i.now_ms - last_act) >= {16'd0, cfg_i.idle_delay_ms});
  assign idle_faded = idle && st_i.idle_faded;

  assign lead      = pal_color(cfg_i.forward_color_index);
  assign trail     = pal_color(cfg_i.backward_color_index);
  assign front_tgt = heading ? lead : trail;
  assign rear_tgt  = heading ? trail : lead;
  assign idx_change = (st_i.seen_fwd_idx != cfg_i.forward_color_index) ||
                      (st_i.seen_bwd_idx != cfg_i.backward_color_index);
  assign front_base = idx_change ? front_tgt : st_i.front_shown;
  assign rear_base  = idx_change ? rear_tgt : st_i.rear_shown;

  assign bat_color   = {8'd0, 8'd255 - item_i.battery_level, item_i.battery_level, 8'd0};
  assign normal_disp = !idle || (cfg_i.idle_display_mode == IDLE_NORMAL);

  lsfc_fade u_fade_front (
    .cur_i  (front_base),
    .want_i (normal_disp ? front_tgt : bat_color),
    .res_o  (front_faded)
  );

  lsfc_fade u_fade_rear (
    .cur_i  (rear_base),
    .want_i (normal_disp ? rear_tgt : bat_color),
    .res_o  (rear_faded)
  );

  // Cell count mod five by reciprocal multiply (exact for six-bit values)
  assign cells_x13 = {4'd0, cfg_i.battery_series_cells} * 10'd13;
  assign cells_q   = cells_x13[9:6];
  assign cells_r   = cfg_i.battery_series_cells - 6'({2'd0, cells_q} * 6'd5);
  assign cells_n   = (cells_r == 6'd0) ? 3'd5 : cells_r[2:0];

  // Battery bar: LED i lit when round(level * LED_COUNT / 255) > i
  assign bar_num = 16'({8'd0, item_i.battery_level} * 16'(2 * LED_COUNT)) + 16'd255;
  always_comb begin
    for (int i = 0; i < LED_COUNT; i++) begin
      bar_mask[i] = (bar_num >= 16'((i + 1) * 510));
    end
  end

  always_comb begin
    preview_mask    = low_bits({2'd0, item_i.press_count});
    preview_mask[6] = 1'b0;
  end

  assign bright_tgt = idle ? idle_lvl(cfg_i.brightness_level)
                           : active_lvl(cfg_i.brightness_level);
  assign cur_ext = {1'b0, st_i.cur_bright};
  assign tgt_ext = {1'b0, bright_tgt};

  always_comb begin
    st_o   = st_i;
    mask_o = mask_i;
    if (menu_preview || menu_mode || menu_cells) begin
      st_o.cur_bright = active_lvl(cfg_i.brightness_level);
      if (menu_preview) begin
        st_o.front_lit = PREVIEW_COLOR;
        st_o.rear_lit  = PREVIEW_COLOR;
        mask_o         = preview_mask;
      end else if (menu_mode) begin
        st_o.front_lit = MODE_COLOR;
        st_o.rear_lit  = MODE_COLOR;
        mask_o         = low_bits({3'd0, 3'({1'b0, cfg_i.idle_display_mode} + 3'd1)});
      end else begin
        st_o.front_lit = CELLS_COLOR;
        st_o.rear_lit  = CELLS_COLOR;
        mask_o         = low_bits({3'd0, cells_n});
      end
    end else begin
      st_o.heading_fwd  = heading;
      st_o.last_act_ms  = last_act;
      st_o.idle_faded   = idle_faded;
      st_o.seen_fwd_idx = cfg_i.forward_color_index;
      st_o.seen_bwd_idx = cfg_i.backward_color_index;
      st_o.front_shown  = front_base;
      st_o.rear_shown   = rear_base;

      if (normal_disp || (idle_faded && cfg_i.idle_display_mode != IDLE_OFF)) begin
        st_o.front_shown = front_faded;
        st_o.rear_shown  = rear_faded;
        st_o.front_lit   = front_faded;
        st_o.rear_lit    = rear_faded;
        if (normal_disp || cfg_i.idle_display_mode == IDLE_BAT_COL) begin
          mask_o = '1;
        end else begin
          mask_o = bar_mask;
        end
      end else if (idle_faded) begin
        st_o.front_lit = '0;
        st_o.rear_lit  = '0;
        mask_o         = '0;
      end

      st_o.seen_bright_lvl = cfg_i.brightness_level;
      if (st_i.seen_bright_lvl != cfg_i.brightness_level) begin
        st_o.cur_bright = bright_tgt;
      end else if (cur_ext > tgt_ext) begin
        st_o.cur_bright = (cur_ext >= tgt_ext + DIM_STEP) ? 8'(cur_ext - DIM_STEP) : bright_tgt;
      end else if (cur_ext < tgt_ext) begin
        st_o.cur_bright = (cur_ext + RISE_STEP <= tgt_ext) ? 8'(cur_ext + RISE_STEP) : bright_tgt;
      end else if (idle) begin
        st_o.idle_faded = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sim/lsfc_result_checker.sv =====
// Checker for the LED strip fade controller: tracks the strip state and compares every result.
`timescale 1ns / 1ps
module lsfc_result_checker
  import lsfc_pkg::*;
#(
  parameter int LedCount = LSFC_LED_COUNT,
  parameter int OutW     = ((64 + LedCount + 8 + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [OutW-1:0]     out_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int                  fail_count,
  output int                  pending,
  output int                  checked
);

  typedef struct packed {
    logic [7:0]          glow;
    logic [LedCount-1:0] leds;
    logic [31:0]         rear;
    logic [31:0]         front;
  } strip_frame_t;

  localparam logic [31:0] WRGB_TABLE [0:6] = '{
    32'hFFFF_FFFF, 32'h0000_00FF, 32'h0000_FFFF, 32'h0000_FF00,
    32'h00FF_FF00, 32'h00FF_0000, 32'h00FF_00FF
  };
  localparam logic [7:0] RIDE_GLOW [0:3] = '{8'hFF, 8'h88, 8'h44, 8'h00};
  localparam logic [7:0] REST_GLOW [0:3] = '{8'h0A, 8'h05, 8'h01, 8'h00};

  lsfc_cfg_t           regs;
  logic                heading_fwd, faded;
  logic [31:0]         last_touch_ms;
  logic [31:0]         front_base, rear_base, front_show, rear_show;
  logic [LedCount-1:0] lit_leds;
  logic [7:0]          glow;
  logic [1:0]          lvl_seen;
  logic [2:0]          fwd_seen, bwd_seen;
  strip_frame_t        awaited_frames [$];

  function automatic logic [31:0] palette_color(input logic [2:0] i);
    return WRGB_TABLE[(i > 3'd6) ? 3'd6 : i];
  endfunction

  function automatic logic [LedCount-1:0] first_leds(input int n);
    logic [LedCount:0] ones;
    if (n >= LedCount) return '1;
    ones = 1;
    ones = (ones << n) - 1'b1;
    return ones[LedCount-1:0];
  endfunction

  // Move each W, R, G, B byte toward its target by 20, landing on it when closer.
  function automatic logic [31:0] fade_wrgb(input logic [31:0] cur, input logic [31:0] want);
    logic [31:0] r;
    int c, d;
    for (int b = 0; b < 4; b++) begin
      c = cur[8*b +: 8];
      d = want[8*b +: 8];
      if ((d > c ? d - c : c - d) < 20) r[8*b +: 8] = 8'(d);
      else if (d > c) r[8*b +: 8] = 8'(c + 20);
      else r[8*b +: 8] = 8'(c - 20);
    end
    return r;
  endfunction

  task automatic clear_model();
    regs = '{RST_BRIGHT_LVL, RST_FWD_IDX, RST_BWD_IDX, RST_IDLE_MODE, RST_CELLS,
             RST_IDLE_DELAY};
    heading_fwd   = 1'b1;
    faded         = 1'b0;
    last_touch_ms = '0;
    front_base    = palette_color(regs.forward_color_index);
    rear_base     = palette_color(regs.backward_color_index);
    front_show    = front_base;
    rear_show     = rear_base;
    lit_leds      = '1;
    glow          = '0;
    lvl_seen      = regs.brightness_level;
    fwd_seen      = regs.forward_color_index;
    bwd_seen      = regs.backward_color_index;
  endtask

  task automatic hold_menu(input logic [31:0] color, input logic [LedCount-1:0] leds);
    front_show = color;
    rear_show  = color;
    lit_leds   = leds;
    glow       = RIDE_GLOW[regs.brightness_level];
  endtask

  task automatic predict_strip(input lsfc_item_t it, output strip_frame_t f);
    logic                menu_done, idle;
    logic [31:0]         lead, trail, bat, since;
    logic [LedCount-1:0] leds;
    int                  n, spd, tgt, cur, lv;
    menu_done = 1'b0;
    if (it.press_count != MENU_NONE) begin
      if (it.long_press_count == 4'd0) begin
        leds    = first_leds(it.press_count);
        leds[6] = 1'b0;
        hold_menu(PREVIEW_COLOR, leds);
        menu_done = 1'b1;
      end else if (it.press_count <= MENU_DIR_LAST) begin
        heading_fwd = (it.press_count != MENU_DIR_REV);
      end else if (it.press_count == MENU_IDLE_SEL) begin
        hold_menu(MODE_COLOR, first_leds(regs.idle_display_mode + 1));
        menu_done = 1'b1;
      end else if (it.press_count == MENU_CELLS) begin
        n = regs.battery_series_cells % 5;
        if (n == 0) n = 5;
        hold_menu(CELLS_COLOR, first_leds(n));
        menu_done = 1'b1;
      end
    end

    if (!menu_done) begin
      lead  = palette_color(regs.forward_color_index);
      trail = palette_color(regs.backward_color_index);
      spd   = $signed(it.motor_speed);
      if (spd > 25) heading_fwd = 1'b1;
      else if (spd < -25) heading_fwd = 1'b0;

      if (it.switch_active) last_touch_ms = it.now_ms;
      since = it.now_ms - last_touch_ms;
      idle  = since >= 32'(regs.idle_delay_ms);
      if (!idle) faded = 1'b0;

      // A new palette selection snaps the fade bases straight to their targets
      if (fwd_seen != regs.forward_color_index || bwd_seen != regs.backward_color_index) begin
        fwd_seen   = regs.forward_color_index;
        bwd_seen   = regs.backward_color_index;
        front_base = heading_fwd ? lead : trail;
        rear_base  = heading_fwd ? trail : lead;
      end

      if (!idle || regs.idle_display_mode == IDLE_NORMAL) begin
        front_base = fade_wrgb(front_base, heading_fwd ? lead : trail);
        rear_base  = fade_wrgb(rear_base, heading_fwd ? trail : lead);
        front_show = front_base;
        rear_show  = rear_base;
        lit_leds   = '1;
      end else if (faded && regs.idle_display_mode != IDLE_OFF) begin
        lv         = it.battery_level;
        bat        = {8'h00, 8'(255 - lv), 8'(lv), 8'h00};
        front_base = fade_wrgb(front_base, bat);
        rear_base  = fade_wrgb(rear_base, bat);
        front_show = front_base;
        rear_show  = rear_base;
        if (regs.idle_display_mode == IDLE_BAT_COL) lit_leds = '1;
        else lit_leds = first_leds((lv * LedCount * 2 + 255) / 510);
      end else if (faded) begin
        front_show = '0;
        rear_show  = '0;
        lit_leds   = '0;
      end

      tgt = idle ? REST_GLOW[regs.brightness_level] : RIDE_GLOW[regs.brightness_level];
      cur = glow;
      if (lvl_seen != regs.brightness_level) begin
        lvl_seen = regs.brightness_level;
        glow     = 8'(tgt);
      end else if (cur > tgt) begin
        glow = 8'((cur >= tgt + 10) ? cur - 10 : tgt);
      end else if (cur < tgt) begin
        glow = 8'((cur + 30 <= tgt) ? cur + 30 : tgt);
      end else if (idle) begin
        faded = 1'b1;
      end
    end

    f.front = front_show;
    f.rear  = rear_show;
    f.leds  = lit_leds;
    f.glow  = glow;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 40)
      $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic compare_frame(input strip_frame_t got);
    strip_frame_t want;
    if (awaited_frames.size() == 0) begin
      report_mismatch("result with no request outstanding", got.front, '0);
      return;
    end
    want = awaited_frames.pop_front();
    checked++;
    if (got.front !== want.front) report_mismatch("front_color", got.front, want.front);
    if (got.rear !== want.rear) report_mismatch("rear_color", got.rear, want.rear);
    if (got.leds !== want.leds) report_mismatch("lit_mask", 32'(got.leds), 32'(want.leds));
    if (got.glow !== want.glow)
      report_mismatch("strip_brightness", 32'(got.glow), 32'(want.glow));
  endtask

  always @(posedge clk) begin : watch
    strip_frame_t f;
    if (!rst_n) begin
      clear_model();
      awaited_frames.delete();
    end else begin
      if (out_tvalid && out_tready) compare_frame(strip_frame_t'(out_tdata[$bits(strip_frame_t)-1:0]));
      if (in_tvalid && in_tready) begin
        predict_strip(lsfc_item_t'(in_tdata[$bits(lsfc_item_t)-1:0]), f);
        awaited_frames.push_back(f);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BRIGHT_LVL: regs.brightness_level     = cfg_wdata[1:0];
          CFG_FWD_IDX:    regs.forward_color_index  = cfg_wdata[2:0];
          CFG_BWD_IDX:    regs.backward_color_index = cfg_wdata[2:0];
          CFG_IDLE_MODE:  regs.idle_display_mode    = cfg_wdata[1:0];
          CFG_CELLS:      regs.battery_series_cells = cfg_wdata[5:0];
          CFG_IDLE_DELAY: regs.idle_delay_ms        = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = awaited_frames.size();
  end

endmodule

// ===== sim/tb_led_strip_fade_controller_core.sv =====
// Testbench top for the LED strip fade controller: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module tb_led_strip_fade_controller_core
  import lsfc_pkg::*;
();

  localparam int OutW       = ((64 + LSFC_LED_COUNT + 8 + 7) / 8) * 8;
  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 119;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic [InDataW-1:0]  in_tdata  = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [OutW-1:0]     out_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_wdata  = '0;

  int fail_count, pending, checked;
  int cycles   = 0;
  int sent     = 0;
  int gap_pct  = 12;   // percent chance that the sender idles before offering, drawn anew while it idles
  int hold_pct = 47;   // percent chance that the receiver stalls

  // Ride generator state: running millisecond clock and ride/rest streaks
  logic [31:0] clock_ms;
  logic        riding;
  int          streak, step_span;

  led_strip_fade_controller_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  lsfc_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #6 clk = ~clk;

  // Stall the result side at the rate of the current pacing phase
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= hold_pct);
  end

  // Watchdog: a lost or stuck result ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("watchdog expired after %0d cycles, %0d results outstanding", cycles, pending);
      $display("led_strip_fade_controller_core verification failed");
      $finish;
    end
  end

  function automatic lsfc_item_t pack_item(input bit sw, input int sp, input logic [31:0] now,
                                           input int pc, input int lpc, input int bat);
    lsfc_item_t it;
    it.switch_active    = sw;
    it.motor_speed      = 21'(sp);
    it.now_ms           = now;
    it.press_count      = 4'(pc);
    it.long_press_count = 4'(lpc);
    it.battery_level    = 8'(bat);
    return it;
  endfunction

  // Offer one request, idle first at random, and hold it until it is taken.
  // Pacing: sender light/receiver heavy, then the reverse, then no idling at all.
  task automatic send_request(input lsfc_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(InDataW - $bits(lsfc_item_t)){1'b0}}, it};
    do @(posedge clk); while (!in_tready);
    sent++;
    if (sent < 325) begin
      gap_pct = 12;
      hold_pct <= 47;
    end else if (sent < 650) begin
      gap_pct = 47;
      hold_pct <= 12;
    end else begin
      gap_pct = 0;
      hold_pct <= 0;
    end
  endtask

  // Drop valid and wait until every outstanding result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic put_reg(input lsfc_cfg_idx_t idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic write_settings(input lsfc_cfg_t s);
    put_reg(CFG_BRIGHT_LVL, 16'(s.brightness_level));
    put_reg(CFG_FWD_IDX,    16'(s.forward_color_index));
    put_reg(CFG_BWD_IDX,    16'(s.backward_color_index));
    put_reg(CFG_IDLE_MODE,  16'(s.idle_display_mode));
    put_reg(CFG_CELLS,      16'(s.battery_series_cells));
    put_reg(CFG_IDLE_DELAY, s.idle_delay_ms);
    cfg_we <= 1'b0;
  endtask

  // Build the next tick of a plausible ride: riding streaks with the foot switch
  // mostly pressed, resting streaks long enough to go idle and fade, time advancing
  // in steps scaled to the idle delay, with rare jumps and occasional menu presses.
  task automatic roll_item(output lsfc_item_t it);
    int pick, sp;
    if (streak == 0) begin
      riding = !riding;
      streak = riding ? $urandom_range(10, 60) : $urandom_range(25, 90);
    end
    streak--;
    it = '0;

    if ($urandom_range(99) < 3) clock_ms = $urandom();
    else clock_ms += $urandom_range(0, step_span);
    it.now_ms        = clock_ms;
    it.switch_active = riding ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);

    pick = $urandom_range(99);
    if (pick < 35) sp = int'($urandom_range(0, 120)) - 60;
    else if (pick < 75) sp = int'($urandom_range(0, 6000)) - 3000;
    else if (pick < 90) sp = int'($urandom_range(0, 2000000)) - 1000000;
    else begin
      case ($urandom_range(3))
        0:       sp = 25;
        1:       sp = 26;
        2:       sp = -25;
        default: sp = -26;
      endcase
    end
    it.motor_speed   = 21'(sp);
    it.battery_level = 8'($urandom_range(255));

    if ($urandom_range(99) < 10) begin
      it.press_count = ($urandom_range(3) == 0) ? 4'($urandom_range(6, 15))
                                                : 4'($urandom_range(1, 5));
      it.long_press_count = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
    end else if ($urandom_range(4) == 0) begin
      // long presses alone must not open a menu
      it.long_press_count = 4'($urandom_range(15));
    end
  endtask

  initial begin : stimulus
    lsfc_cfg_t  plan [0:7];
    lsfc_item_t it;

    plan[0] = '{2'd3, 3'd7, 3'd0, IDLE_BAT_COL, 6'd5,  16'd0};
    plan[1] = '{2'd1, 3'd6, 3'd1, IDLE_BAT_BAR, 6'd32, 16'd150};
    plan[2] = '{2'd2, 3'd2, 3'd3, IDLE_OFF,     6'd1,  16'd400};
    plan[3] = '{2'd0, 3'd4, 3'd4, IDLE_NORMAL,  6'd7,  16'd65535};
    plan[4] = '{2'd0, 3'd3, 3'd6, IDLE_BAT_BAR, 6'd10, 16'd300};
    plan[5] = '{2'd1, 3'd1, 3'd2, IDLE_BAT_COL, 6'd13, 16'd1000};
    plan[6] = '{2'd3, 3'd5, 3'd7, IDLE_OFF,     6'd31, 16'd50};
    plan[7].brightness_level     = 2'($urandom_range(3));
    plan[7].forward_color_index  = 3'($urandom_range(7));
    plan[7].backward_color_index = 3'($urandom_range(7));
    plan[7].idle_display_mode    = 2'($urandom_range(3));
    plan[7].battery_series_cells = 6'($urandom_range(1, 32));
    plan[7].idle_delay_ms        = 16'($urandom_range(0, 2000));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks at the reset settings (idle delay 2000 ms)
    send_request(pack_item(0, 0, 32'd0, 0, 0, 0));
    send_request(pack_item(1, 26, 32'd100, 0, 0, 255));        // just outside the deadband
    send_request(pack_item(1, 25, 32'd200, 0, 0, 1));          // deadband edge, heading holds
    send_request(pack_item(1, -25, 32'd300, 0, 0, 128));
    send_request(pack_item(1, -26, 32'd400, 0, 0, 0));         // flip to reverse, palette swaps
    send_request(pack_item(1, 1000000, 32'd500, 0, 0, 255));
    send_request(pack_item(1, -1000000, 32'd600, 0, 0, 77));
    send_request(pack_item(0, 0, 32'd700, 1, 0, 0));           // menu preview, one LED
    send_request(pack_item(0, 0, 32'd710, 7, 0, 0));           // preview keeps LED six dark
    send_request(pack_item(0, 0, 32'd720, 15, 0, 0));          // preview clipped to the strip
    send_request(pack_item(0, 0, 32'd730, 3, 15, 0));          // menu three: reverse
    send_request(pack_item(0, 0, 32'd740, 1, 1, 0));           // menu one: forward
    send_request(pack_item(0, -40, 32'd750, 2, 2, 0));         // menu two, then speed overrides
    send_request(pack_item(0, 0, 32'd760, 4, 1, 0));           // idle mode menu
    send_request(pack_item(0, 0, 32'd770, 5, 9, 0));           // cell count menu
    send_request(pack_item(0, 0, 32'd780, 6, 1, 0));           // menu without a display
    send_request(pack_item(0, 0, 32'd790, 15, 15, 0));
    send_request(pack_item(1, 0, 32'hFFFF_FFFF, 0, 0, 255));   // activity at the top of time
    send_request(pack_item(0, 0, 32'h0000_0100, 0, 0, 255));   // timer wraps, still active
    send_request(pack_item(0, 0, 32'h0000_1000, 0, 0, 0));     // past the delay: idle
    send_request(pack_item(0, 0, 32'hFFFF_FFFF, 0, 15, 255));

    // Random rides, one register setting per phase; write registers only when idle
    for (int p = 0; p < 8; p++) begin
      drain();
      write_settings(plan[p]);
      step_span = plan[p].idle_delay_ms / 8 + 20;
      clock_ms  = (p % 3 == 1) ? 32'hFFFF_F000 : $urandom();
      riding    = 1'b1;
      streak    = $urandom_range(5, 30);
      for (int i = 0; i < PhaseItems; i++) begin
        roll_item(it);
        send_request(it);
      end
    end

    drain();
    $display("Sent %0d requests across eight register settings; %0d results compared.",
             sent, checked);
    $display("Covered menus, deadband edges, palette swaps, timer wrap and all idle modes.");
    if (fail_count == 0) begin
      $display("led_strip_fade_controller_core verification clean");
    end else begin
      $display("led_strip_fade_controller_core verification failed");
    end
    $finish;
  end

endmodule
